### hw/rtl/environ_subneg_parser_assert.svh
// ----------------------------------------------------------------------------
// environ_subneg_parser assertion macros
// shared property wrappers for the parser's checker
// ----------------------------------------------------------------------------
`ifndef ENVIRON_SUBNEG_PARSER_ASSERT_SVH
`define ENVIRON_SUBNEG_PARSER_ASSERT_SVH

// clocked assertion, quiet while reset is asserted
`define ESP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("environ_subneg_parser assertion failed");

// clocked assertion that also holds across reset
`define ESP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("environ_subneg_parser reset assertion failed");

`endif

### hw/rtl/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg
// shared codes, limits and types of the new-environ payload parser
// ----------------------------------------------------------------------------
package esp_pkg;

  // command byte codes
  localparam logic [7:0] CMD_IS   = 8'd0;
  localparam logic [7:0] CMD_INFO = 8'd2;

  // marker byte codes
  localparam logic [7:0] MK_VAR     = 8'd0;
  localparam logic [7:0] MK_VALUE   = 8'd1;
  localparam logic [7:0] MK_ESC     = 8'd2;
  localparam logic [7:0] MK_USERVAR = 8'd3;

  // parse phases
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_NAME  = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_CMD       = 3'd1;
  localparam logic [2:0] EV_ENTRY     = 3'd2;
  localparam logic [2:0] EV_NAME_BYTE = 3'd3;
  localparam logic [2:0] EV_VAL_START = 3'd4;
  localparam logic [2:0] EV_VAL_BYTE  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CMD    = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER = 3'd2;
  localparam logic [2:0] ST_TOO_MANY   = 3'd3;
  localparam logic [2:0] ST_EMPTY_NAME = 3'd4;
  localparam logic [2:0] ST_NAME_LONG  = 3'd5;
  localparam logic [2:0] ST_VALUE_LONG = 3'd6;
  localparam logic [2:0] ST_BAD_VALUE  = 3'd7;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd2;

  localparam logic [8:0]  NAME_LIMIT_RST  = 9'd256;
  localparam logic [12:0] VALUE_LIMIT_RST = 13'd4096;
  localparam logic [6:0]  ENTRY_LIMIT_RST = 7'd64;

  typedef struct packed {
    logic [8:0]  name_limit;
    logic [12:0] value_limit;
    logic [6:0]  entry_limit;
  } esp_lim_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        esc;
    logic [8:0]  name_len;
    logic [12:0] value_len;
    logic [6:0]  entry_cnt;
    logic        kind;
    logic        info;
    logic [2:0]  err;
  } esp_state_t;

  localparam esp_state_t STATE_RST = '{
    phase:     PH_CMD,
    esc:       1'b0,
    name_len:  9'd0,
    value_len: 13'd0,
    entry_cnt: 7'd0,
    kind:      1'b0,
    info:      1'b0,
    err:       ST_OK
  };

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data;
    logic       kind;
    logic [5:0] number;
    logic       info;
    logic       done;
    logic [2:0] status;
  } esp_res_t;

endpackage

### hw/rtl/esp_cfg.sv
// ----------------------------------------------------------------------------
// esp_cfg
// limit registers written through the plain configuration port
// ----------------------------------------------------------------------------
module esp_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output esp_pkg::esp_lim_t                  lim
);

  esp_pkg::esp_lim_t lim_r, lim_nxt;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_we) begin
      case (cfg_index)
        esp_pkg::REG_NAME_LIMIT:  lim_nxt.name_limit  = cfg_data[8:0];
        esp_pkg::REG_VALUE_LIMIT: lim_nxt.value_limit = cfg_data[12:0];
        esp_pkg::REG_ENTRY_LIMIT: lim_nxt.entry_limit = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.name_limit  <= esp_pkg::NAME_LIMIT_RST;
      lim_r.value_limit <= esp_pkg::VALUE_LIMIT_RST;
      lim_r.entry_limit <= esp_pkg::ENTRY_LIMIT_RST;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  assign lim = lim_r;

endmodule

### hw/rtl/esp_step.sv
// ----------------------------------------------------------------------------
// esp_step
// one-byte parse step: next parser state and the result for that byte
// ----------------------------------------------------------------------------
module esp_step (
  input  esp_pkg::esp_state_t st,
  input  esp_pkg::esp_lim_t   lim,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output esp_pkg::esp_state_t st_nxt,
  output esp_pkg::esp_res_t   res
);

  esp_pkg::esp_state_t s;
  logic [2:0]          ev;
  logic [7:0]          ob;
  logic                do_entry;
  logic                do_lit;

  always_comb begin
    s        = st;
    ev       = esp_pkg::EV_NONE;
    ob       = 8'd0;
    do_entry = 1'b0;
    do_lit   = 1'b0;

    if (st.err == esp_pkg::ST_OK) begin
      if (st.phase == esp_pkg::PH_CMD) begin
        if (data_byte inside {esp_pkg::CMD_IS, esp_pkg::CMD_INFO}) begin
          s.info  = (data_byte == esp_pkg::CMD_INFO);
          s.phase = esp_pkg::PH_MARK;
          ev      = esp_pkg::EV_CMD;
        end else begin
          s.err = esp_pkg::ST_BAD_CMD;
        end
      end else if (st.esc) begin
        s.esc  = 1'b0;
        do_lit = 1'b1;
      end else if (st.phase == esp_pkg::PH_MARK) begin
        do_entry = 1'b1;
      end else if (st.phase == esp_pkg::PH_NAME) begin
        if (data_byte inside {esp_pkg::MK_VAR, esp_pkg::MK_USERVAR, esp_pkg::MK_VALUE}) begin
          if (st.name_len == 9'd0) begin
            s.err = esp_pkg::ST_EMPTY_NAME;
          end else if (data_byte == esp_pkg::MK_VALUE) begin
            s.phase     = esp_pkg::PH_VALUE;
            s.value_len = 13'd0;
            ev          = esp_pkg::EV_VAL_START;
          end else begin
            do_entry = 1'b1;
          end
        end else if (data_byte == esp_pkg::MK_ESC) begin
          s.esc = 1'b1;
        end else begin
          do_lit = 1'b1;
        end
      end else begin
        if (data_byte inside {esp_pkg::MK_VAR, esp_pkg::MK_USERVAR}) begin
          do_entry = 1'b1;
        end else if (data_byte == esp_pkg::MK_VALUE) begin
          s.err = esp_pkg::ST_BAD_VALUE;
        end else if (data_byte == esp_pkg::MK_ESC) begin
          s.esc = 1'b1;
        end else begin
          do_lit = 1'b1;
        end
      end

      // new entry marker
      if (do_entry) begin
        if (!(data_byte inside {esp_pkg::MK_VAR, esp_pkg::MK_USERVAR})) begin
          s.err = esp_pkg::ST_BAD_MARKER;
        end else if (st.entry_cnt >= lim.entry_limit) begin
          s.err = esp_pkg::ST_TOO_MANY;
        end else begin
          s.entry_cnt = st.entry_cnt + 7'd1;
          s.kind      = (data_byte == esp_pkg::MK_USERVAR);
          s.name_len  = 9'd0;
          s.value_len = 13'd0;
          s.phase     = esp_pkg::PH_NAME;
          ev          = esp_pkg::EV_ENTRY;
        end
      end

      // literal name or value byte
      if (do_lit) begin
        if (st.phase == esp_pkg::PH_NAME) begin
          if (st.name_len >= lim.name_limit) begin
            s.err = esp_pkg::ST_NAME_LONG;
          end else begin
            s.name_len = st.name_len + 9'd1;
            ev         = esp_pkg::EV_NAME_BYTE;
            ob         = data_byte;
          end
        end else begin
          if (st.value_len >= lim.value_limit) begin
            s.err = esp_pkg::ST_VALUE_LONG;
          end else begin
            s.value_len = st.value_len + 13'd1;
            ev          = esp_pkg::EV_VAL_BYTE;
            ob          = data_byte;
          end
        end
      end

      // checks at the end of the payload
      if (last_byte && s.err == esp_pkg::ST_OK) begin
        if (s.esc) begin
          s.err = esp_pkg::ST_BAD_VALUE;
        end else if (s.phase == esp_pkg::PH_NAME && s.name_len == 9'd0) begin
          s.err = esp_pkg::ST_EMPTY_NAME;
        end
      end
    end
  end

  always_comb begin
    res.event_res = ev;
    res.data      = ob;
    res.kind      = s.kind;
    res.number    = (s.entry_cnt == 7'd0) ? 6'd0 : 6'(s.entry_cnt - 7'd1);
    res.info      = s.info;
    res.done      = last_byte;
    res.status    = s.err;
  end

  assign st_nxt = last_byte ? esp_pkg::STATE_RST : s;

endmodule

### hw/rtl/environ_subneg_parser.sv
// ----------------------------------------------------------------------------
// environ_subneg_parser
// result path: an accepted byte passes the input register, the parse step and
//   the result register before out_valid rises for it
// throughput: one byte per cycle while out_stall is low, set by the
//   combinational parse step between the input register and result register
// reset: synchronous active-low rst_n empties both stages, returns the parse
//   state to "expect command byte" and loads the limits 256 / 4096 / 64
// ----------------------------------------------------------------------------
// Parser for telnet NEW-ENVIRON subnegotiation payloads. Each input item is
// one payload byte; each gives exactly one result item describing what the
// byte meant (command, entry start, name byte, value start, value byte or
// nothing) plus the current entry context and the latched status.
module environ_subneg_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_event_res,
  output logic [7:0]                     out_out_byte,
  output logic                           out_entry_kind,
  output logic [5:0]                     out_entry_number,
  output logic                           out_is_info,
  output logic                           out_done_res,
  output logic [2:0]                     out_status
);

  esp_pkg::esp_lim_t   lim;

  // input stage
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parse state, only moves when an item passes to the result register
  esp_pkg::esp_state_t st_r, st_nxt, step_st;
  esp_pkg::esp_res_t   step_res;

  // result stage
  logic              out_v_r, out_v_nxt;
  esp_pkg::esp_res_t out_res_r;

  logic in_take;   // item enters the input register
  logic out_open;  // result register can load this cycle
  logic adv;       // item moves from input register to result register

  esp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lim       (lim)
  );

  esp_step u_step (
    .st        (st_r),
    .lim       (lim),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .st_nxt    (step_st),
    .res       (step_res)
  );

  // result register frees up when empty or being taken this cycle
  assign out_open = !out_v_r || !out_stall;
  assign adv      = s1_v_r && out_open;
  // input register holds its item only while the result side is blocked
  assign in_stall = s1_v_r && !out_open;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_open) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end

    st_nxt = adv ? step_st : st_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= esp_pkg::STATE_RST;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_event_res    = out_res_r.event_res;
  assign out_out_byte     = out_res_r.data;
  assign out_entry_kind   = out_res_r.kind;
  assign out_entry_number = out_res_r.number;
  assign out_is_info      = out_res_r.info;
  assign out_done_res     = out_res_r.done;
  assign out_status       = out_res_r.status;

endmodule

### hw/rtl/esp_chk.sv
// ----------------------------------------------------------------------------
// esp_chk
// port-level checks of the parser, bound to the top level
// ----------------------------------------------------------------------------
`include "environ_subneg_parser_assert.svh"

module esp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_res,
  input logic [7:0] out_out_byte,
  input logic       out_entry_kind,
  input logic [5:0] out_entry_number,
  input logic       out_is_info,
  input logic       out_done_res,
  input logic [2:0] out_status
);

  logic [22:0] out_fields;   // every result field
  logic        out_held;     // result offered but held off
  logic        out_err_mid;  // error status on a byte that is not the last
  logic        out_no_lit;   // result is not a name or value byte
  logic        out_cmd;      // result is a command byte

  assign out_fields  = {out_event_res, out_out_byte, out_entry_kind, out_entry_number,
                        out_is_info, out_done_res, out_status};
  assign out_held    = out_valid && out_stall;
  assign out_err_mid = out_valid && !out_done_res && out_status != esp_pkg::ST_OK;
  assign out_no_lit  = out_valid && out_event_res != esp_pkg::EV_NAME_BYTE &&
                       out_event_res != esp_pkg::EV_VAL_BYTE;
  assign out_cmd     = out_valid && out_event_res == esp_pkg::EV_CMD;

  // a stalled result stays put
  `ESP_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_fields))

  // nothing comes out in the cycle after reset
  `ESP_ASSERT_NR(a_rst_empty, clk, !rst_n |=> !out_valid)

  // an error before the last byte silences the event; on the last byte an
  // entry start still shows up with the empty-name status
  `ESP_ASSERT(a_err_no_event, clk, rst_n, out_err_mid |-> out_event_res == esp_pkg::EV_NONE)

  // only name and value bytes carry data
  `ESP_ASSERT(a_byte_zero, clk, rst_n, out_no_lit |-> out_out_byte == 8'd0)

  // a command byte opens a payload with no entry context yet
  `ESP_ASSERT(a_cmd_fresh, clk, rst_n, out_cmd |-> out_entry_number == 6'd0 && !out_entry_kind)

endmodule

bind environ_subneg_parser esp_chk u_esp_chk (.*);
